@@ src/assert_macros.svh @@
// assertion macros shared by the rational accumulator modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, clocked on clk and disabled in reset
`define RAT_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// next-cycle implication, clocked on clk and disabled in reset
`define RAT_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

@@ src/rat_alu_pkg.sv @@
// shared types and constants for the rational accumulator
`timescale 1ns / 1ps

package rat_alu_pkg;

  localparam int DATA_BITS = 32;
  localparam int CMD_BITS  = 3;

  // command codes
  localparam logic [CMD_BITS-1:0] CMD_LOAD = 3'd0;
  localparam logic [CMD_BITS-1:0] CMD_ADD  = 3'd1;
  localparam logic [CMD_BITS-1:0] CMD_SUB  = 3'd2;
  localparam logic [CMD_BITS-1:0] CMD_MUL  = 3'd3;
  localparam logic [CMD_BITS-1:0] CMD_DIV  = 3'd4;

  // operations of the shared shift/add unit
  typedef enum logic [0:0] {
    UOP_MUL = 1'b0,
    UOP_DIV = 1'b1
  } unit_op_t;

  typedef struct packed {
    logic     start;
    unit_op_t op;
  } unit_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

@@ src/rat_alu_in_if.sv @@
// input channel carrying a command and an operand fraction
`timescale 1ns / 1ps

interface rat_alu_in_if import rat_alu_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic [CMD_BITS-1:0]         cmd;
  logic signed [DATA_BITS-1:0] op_num;
  logic signed [DATA_BITS-1:0] op_den;

  modport source (output valid, output cmd, output op_num, output op_den, input ready);
  modport sink   (input valid, input cmd, input op_num, input op_den, output ready);
endinterface

@@ src/rat_alu_out_if.sv @@
// output channel carrying the accumulator result
`timescale 1ns / 1ps

interface rat_alu_out_if import rat_alu_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic signed [DATA_BITS-1:0] res_num;
  logic signed [DATA_BITS-1:0] res_den;
  logic signed [DATA_BITS-1:0] int_part;
  logic                        illegal;

  modport source (output valid, output res_num, output res_den, output int_part,
                  output illegal, input ready);
  modport sink   (input valid, input res_num, input res_den, input int_part,
                  input illegal, output ready);
endinterface

@@ src/rat_alu_unit.sv @@
// shared bit-serial unit: wrapping shift-add multiply and signed truncating divide
`timescale 1ns / 1ps

module rat_alu_unit import rat_alu_pkg::*; #(
  parameter int W = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  unit_req_t  req,
  input  logic [W-1:0] opa,
  input  logic [W-1:0] opb,
  output unit_stat_t stat,
  output logic [W-1:0] res,
  output logic [W-1:0] rem
);

  `include "assert_macros.svh"

  localparam int CW = $clog2(W);
  localparam int SW = W + 2;

  logic [W-1:0]  p;
  logic [W-1:0]  s;
  logic [W-1:0]  q;
  logic          neg_q;
  logic          neg_r;
  unit_op_t      op;
  logic [CW-1:0] cnt;
  logic          busy;
  logic          done;

  logic [W-1:0]  mag_a;
  logic [W-1:0]  mag_b;
  logic [W:0]    rs;
  logic [W:0]    add_x;
  logic [W:0]    add_y;
  logic [SW-1:0] sum;
  logic          is_div;
  logic          fits;

  // operand magnitudes for the divide
  assign mag_a = opa[W-1] ? (~opa + W'(1)) : opa;
  assign mag_b = opb[W-1] ? (~opb + W'(1)) : opb;

  // one adder: accumulate for multiply, trial subtract for divide
  assign is_div = (op == UOP_DIV);
  assign rs     = {p, q[W-1]};
  assign add_x  = is_div ? rs : {1'b0, p};
  assign add_y  = is_div ? ~{1'b0, s} : {1'b0, s};
  assign sum    = {1'b0, add_x} + {1'b0, add_y} + SW'(is_div);
  assign fits   = sum[SW-1];

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      // done pulses for one cycle after the last step
      done <= busy && !req.start && (cnt == '0);
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CW'(W - 1);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == '0) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // datapath, one bit per cycle
  always_ff @(posedge clk) begin
    if (req.start) begin
      op <= req.op;
      p  <= '0;
      if (req.op == UOP_MUL) begin
        s     <= opa;
        q     <= opb;
        neg_q <= 1'b0;
        neg_r <= 1'b0;
      end else begin
        s     <= mag_b;
        q     <= mag_a;
        neg_q <= opa[W-1] ^ opb[W-1];
        neg_r <= opa[W-1];
      end
    end else if (busy) begin
      if (is_div) begin
        if (fits) begin
          p <= sum[W-1:0];
          q <= {q[W-2:0], 1'b1};
        end else begin
          p <= rs[W-1:0];
          q <= {q[W-2:0], 1'b0};
        end
      end else begin
        if (q[0]) begin
          p <= sum[W-1:0];
        end
        s <= {s[W-2:0], 1'b0};
        q <= {1'b0, q[W-1:1]};
      end
    end
  end

  // signed results
  assign res = is_div ? (neg_q ? (~q + W'(1)) : q) : p;
  assign rem = neg_r ? (~p + W'(1)) : p;

  assign stat.busy = busy;
  assign stat.done = done;

  `RAT_ASSERT_IMP(a_start_when_idle, req.start, !busy && !done, "unit started while working")
  `RAT_ASSERT_IMP(a_done_after_busy, done, $past(busy), "done without a preceding pass")
  `RAT_ASSERT_NEXT(a_start_sets_busy, req.start, busy && !done, "start did not begin a pass")

endmodule

@@ src/rational_accumulator_alu_top.sv @@
// Rational accumulator ALU: keeps a fraction and folds operand fractions into it.
// Channels: item (sink) brings cmd, op_num and op_den; result (source) returns
// res_num, res_den, int_part and illegal. Both move one transaction when valid and
// ready are high at a rising edge. Each item gives exactly one result.
// Work: every multiply or divide runs through one shared bit-serial unit. An item's
// work is set by D, the count of divides (one per Euclid step, two per reduction,
// one for the integer part), M, its 0, 2 or 3 multiplies, and S, the sequencer steps.
// The Euclid loop sets the spread: an illegal load needs no unit pass at all, while a
// subtract with long reductions runs the longest.
// One item is in work at a time; item.ready is high only while the sequencer idles.
// The result sits in an output register; a new item may be taken while it waits,
// and a later result waits in the sequencer until the register is free.
// Reset (rst, synchronous) sets the accumulator to 0/1, empties the output register
// and returns the sequencer to idle.
`timescale 1ns / 1ps

module rational_accumulator_alu_top import rat_alu_pkg::*; #(
  parameter int WORD_BITS = 32
) (
  input logic          clk,
  input logic          rst,
  rat_alu_in_if.sink   item,
  rat_alu_out_if.source result
);

  `include "assert_macros.svh"

  localparam int W = WORD_BITS;

  typedef enum logic [21:0] {
    ST_IDLE  = 22'h000001,
    ST_OPRED = 22'h000002,
    ST_OPSET = 22'h000004,
    ST_BSET  = 22'h000008,
    ST_CHECK = 22'h000010,
    ST_MDEN  = 22'h000020,
    ST_MDENW = 22'h000040,
    ST_MNUM  = 22'h000080,
    ST_MNUMW = 22'h000100,
    ST_MCRS  = 22'h000200,
    ST_MCRSW = 22'h000400,
    ST_FIN   = 22'h000800,
    ST_ASET  = 22'h001000,
    ST_QUOT  = 22'h002000,
    ST_QUOTW = 22'h004000,
    ST_OUT   = 22'h008000,
    ST_GCD   = 22'h010000,
    ST_GCDW  = 22'h020000,
    ST_DNUM  = 22'h040000,
    ST_DNUMW = 22'h080000,
    ST_DDEN  = 22'h100000,
    ST_DDENW = 22'h200000
  } state_t;

  state_t state;
  state_t ret;

  logic [CMD_BITS-1:0] cmd_r;
  logic [W-1:0] an;
  logic [W-1:0] ad;
  logic [W-1:0] bn;
  logic [W-1:0] bd;
  logic [W-1:0] xn;
  logic [W-1:0] xd;
  logic [W-1:0] ga;
  logic [W-1:0] gb;
  logic [W-1:0] ip;

  logic                 out_valid;
  logic [DATA_BITS-1:0] out_num;
  logic [DATA_BITS-1:0] out_den;
  logic [DATA_BITS-1:0] out_int;
  logic                 out_ill;

  unit_req_t    ureq;
  unit_stat_t   ustat;
  logic [W-1:0] uopa;
  logic [W-1:0] uopb;
  logic [W-1:0] ures;
  logic [W-1:0] urem;
  logic         add_like;

  assign add_like = (cmd_r == CMD_ADD) || (cmd_r == CMD_SUB);

  // shared unit requests, issued for one cycle from the issue states
  always_comb begin
    ureq.start = 1'b0;
    ureq.op    = UOP_MUL;
    uopa       = an;
    uopb       = ad;
    unique case (state)
      ST_MDEN: begin
        ureq.start = 1'b1;
        uopa       = ad;
        uopb       = bd;
      end
      ST_MNUM: begin
        ureq.start = 1'b1;
        uopa       = an;
        uopb       = add_like ? bd : bn;
      end
      ST_MCRS: begin
        ureq.start = 1'b1;
        uopa       = ad;
        uopb       = bn;
      end
      ST_QUOT: begin
        ureq.start = (ad != '0);
        ureq.op    = UOP_DIV;
        uopa       = an;
        uopb       = ad;
      end
      ST_GCD: begin
        ureq.start = (gb != '0);
        ureq.op    = UOP_DIV;
        uopa       = ga;
        uopb       = gb;
      end
      ST_DNUM: begin
        ureq.start = 1'b1;
        ureq.op    = UOP_DIV;
        uopa       = xn;
        uopb       = ga;
      end
      ST_DDEN: begin
        ureq.start = 1'b1;
        ureq.op    = UOP_DIV;
        uopa       = xd;
        uopb       = ga;
      end
      default: ;
    endcase
  end

  rat_alu_unit #(
    .W (W)
  ) u_unit (
    .clk  (clk),
    .rst  (rst),
    .req  (ureq),
    .opa  (uopa),
    .opb  (uopb),
    .stat (ustat),
    .res  (ures),
    .rem  (urem)
  );

  // sequencer and working registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      ret       <= ST_IDLE;
      an        <= '0;
      ad        <= W'(1);
      out_valid <= 1'b0;
    end else begin
      // output register empties on a transaction unless it is refilled below
      if (out_valid && result.ready && (state != ST_OUT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (item.valid) begin
            cmd_r <= item.cmd;
            bn    <= W'(item.op_num);
            bd    <= W'(item.op_den);
            state <= ST_OPRED;
          end
        end
        // operand reduction when both parts are nonzero
        ST_OPRED: begin
          xn  <= bn;
          xd  <= bd;
          ga  <= bn;
          gb  <= bd;
          ret <= ST_OPSET;
          if (bn != '0 && bd != '0) begin
            state <= ST_GCD;
          end else begin
            state <= ST_OPSET;
          end
        end
        // command dispatch on the reduced operand
        ST_OPSET: begin
          bn <= xn;
          bd <= xd;
          unique case (cmd_r) inside
            CMD_LOAD: begin
              an    <= xn;
              ad    <= xd;
              state <= ST_QUOT;
            end
            CMD_ADD, CMD_MUL: begin
              state <= ST_CHECK;
            end
            CMD_SUB: begin
              if (xd == '0) begin
                state <= ST_CHECK;
              end else begin
                xn    <= ~xn + W'(1);
                ret   <= ST_BSET;
                state <= ST_FIN;
              end
            end
            CMD_DIV: begin
              if (xn == '0) begin
                ad <= '0;
              end
              xn  <= xd;
              xd  <= xn;
              ga  <= xd;
              gb  <= xn;
              ret <= ST_BSET;
              if (xn != '0 && xd != '0) begin
                state <= ST_GCD;
              end else begin
                state <= ST_BSET;
              end
            end
            default: begin
              state <= ST_QUOT;
            end
          endcase
        end
        ST_BSET: begin
          bn    <= xn;
          bd    <= xd;
          state <= ST_CHECK;
        end
        // a zero denominator on either side marks illegal
        ST_CHECK: begin
          if (ad == '0 || bd == '0) begin
            ad    <= '0;
            state <= ST_QUOT;
          end else begin
            state <= ST_MDEN;
          end
        end
        ST_MDEN: state <= ST_MDENW;
        ST_MDENW: begin
          if (ustat.done) begin
            xd    <= ures;
            state <= ST_MNUM;
          end
        end
        ST_MNUM: state <= ST_MNUMW;
        ST_MNUMW: begin
          if (ustat.done) begin
            xn    <= ures;
            ret   <= ST_ASET;
            state <= add_like ? ST_MCRS : ST_FIN;
          end
        end
        ST_MCRS: state <= ST_MCRSW;
        ST_MCRSW: begin
          if (ustat.done) begin
            xn    <= xn + ures;
            state <= ST_FIN;
          end
        end
        // zero numerator gives 0/1, anything else is reduced
        ST_FIN: begin
          if (xn == '0) begin
            xd    <= W'(1);
            state <= ret;
          end else begin
            ga    <= xn;
            gb    <= xd;
            state <= ST_GCD;
          end
        end
        ST_ASET: begin
          an    <= xn;
          ad    <= xd;
          state <= ST_QUOT;
        end
        // truncated integer part
        ST_QUOT: begin
          if (ad != '0) begin
            state <= ST_QUOTW;
          end else begin
            ip    <= '0;
            state <= ST_OUT;
          end
        end
        ST_QUOTW: begin
          if (ustat.done) begin
            ip    <= ures;
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_valid || result.ready) begin
            out_num   <= DATA_BITS'($signed(an));
            out_den   <= DATA_BITS'($signed(ad));
            out_int   <= DATA_BITS'($signed(ip));
            out_ill   <= (ad == '0);
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        // euclid loop on truncating remainders
        ST_GCD: begin
          if (gb == '0) begin
            state <= ST_DNUM;
          end else begin
            state <= ST_GCDW;
          end
        end
        ST_GCDW: begin
          if (ustat.done) begin
            ga    <= gb;
            gb    <= urem;
            state <= ST_GCD;
          end
        end
        ST_DNUM: state <= ST_DNUMW;
        ST_DNUMW: begin
          if (ustat.done) begin
            xn    <= ures;
            state <= ST_DDEN;
          end
        end
        ST_DDEN: state <= ST_DDENW;
        ST_DDENW: begin
          if (ustat.done) begin
            xd    <= ures;
            state <= ret;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign item.ready      = (state == ST_IDLE) && !rst;
  assign result.valid    = out_valid;
  assign result.res_num  = out_num;
  assign result.res_den  = out_den;
  assign result.int_part = out_int;
  assign result.illegal  = out_ill;

  `RAT_ASSERT_IMP(a_ready_unit_idle, item.ready, !ustat.busy, "ready while unit works")
  `RAT_ASSERT_NEXT(a_accept_drops_ready, item.valid && item.ready, !item.ready, "ready held after accept")
  `RAT_ASSERT_IMP(a_illegal_int_zero, result.valid && result.illegal, result.int_part == '0, "illegal with integer part")

endmodule
